### src/bsia_pkg.sv
package bsia_pkg;

  typedef enum logic [3:0] {
    OP_ENCODE = 4'd0,
    OP_DECODE = 4'd1,
    OP_ABS    = 4'd2,
    OP_ADD    = 4'd3,
    OP_SUB    = 4'd4,
    OP_MUL    = 4'd5,
    OP_DIV    = 4'd6,
    OP_EQ     = 4'd7,
    OP_LT     = 4'd8,
    OP_GT     = 4'd9
  } op_e;

  typedef enum logic [1:0] {
    FAULT_NONE = 2'd0,
    FAULT_DIV0 = 2'd1,
    FAULT_SAT  = 2'd2
  } fault_e;

  // Extra exponent bits: 16^3 shifts a mantissa left by 12.
  localparam int unsigned ExpShift = 12;

endpackage

### src/base16_scaled_int_alu_top.sv
// Channel | Dir | tdata (lowest bit up)                              | tuser
// s_axis  | in  | a_mantissa, a_exponent, b_mantissa, b_exponent,    | opcode, b_is_plain
//         |     | plain_value, zero pad                              |
// m_axis  | out | wide_result, packed_mantissa, packed_exponent,     | fault
//         |     | compare_true, zero pad                             |
//
// One word per cycle in and out while m_axis_tready stays high. The pipe is
// MANTISSA_WIDTH + 21 registers deep: the input register, three front stages, one
// divider cell per quotient bit (MANTISSA_WIDTH+12), a sign stage, three packing cells
// and the output register.
// Every stage holds its own valid and takes a new word whenever it is empty
// or its successor takes; bubbles collapse under a stalled m_axis_tready.
// Reset clears the valid bits only; the data registers are not reset.
module base16_scaled_int_alu_top #(
  parameter int unsigned MANTISSA_WIDTH = 30
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [((2*MANTISSA_WIDTH+68+7)/8)*8-1:0] s_axis_tdata,
  input  logic [4:0] s_axis_tuser,  // opcode, b_is_plain
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [((MANTISSA_WIDTH+67+7)/8)*8-1:0] m_axis_tdata,
  output logic [1:0] m_axis_tuser   // fault
);

  localparam int unsigned MW   = MANTISSA_WIDTH;
  localparam int unsigned QW   = MW + bsia_pkg::ExpShift;
  localparam int unsigned OW   = ((MW + 67 + 7) / 8) * 8;
  localparam int unsigned DPW  = 133;  // wide, src, cmp, fault, is_div, neg
  localparam int unsigned EPW  = 67;   // wide, cmp, fault
  localparam logic signed [64:0] MaxVal = (65'sd1 <<< (MW - 1)) - 65'sd1;
  localparam logic signed [64:0] MinVal = -MaxVal;

  // ---------------- stage 0: input word ----------------
  logic          v0_q, r0;
  logic [3:0]    op0_q;
  logic [MW-1:0] am0_q, bm0_q;
  logic [1:0]    ae0_q, be0_q;
  logic          bp0_q;
  logic [63:0]   pv0_q;
  logic          r1;

  assign r0            = !v0_q || r1;
  assign s_axis_tready = r0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (r0) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r0 && s_axis_tvalid) begin
      op0_q <= s_axis_tuser[3:0];
      bp0_q <= s_axis_tuser[4];
      am0_q <= s_axis_tdata[MW-1:0];
      ae0_q <= s_axis_tdata[MW+1:MW];
      bm0_q <= s_axis_tdata[2*MW+1:MW+2];
      be0_q <= s_axis_tdata[2*MW+3:2*MW+2];
      pv0_q <= s_axis_tdata[2*MW+67:2*MW+4];
    end
  end

  // ---------------- stage 1: unpack operands ----------------
  logic        v1_q, r2;
  logic [3:0]  op1_q;
  logic [63:0] a1_q, b1_q, pv1_q, a_dec, b_dec;

  assign r1 = !v1_q || r2;

  always_comb begin
    a_dec = {{(64 - MW){am0_q[MW-1]}}, am0_q} << {ae0_q, 2'b00};
    b_dec = bp0_q ? pv0_q : ({{(64 - MW){bm0_q[MW-1]}}, bm0_q} << {be0_q, 2'b00});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (r1) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1 && v0_q) begin
      op1_q <= op0_q;
      a1_q  <= a_dec;
      b1_q  <= b_dec;
      pv1_q <= pv0_q;
    end
  end

  // ---------------- stage 2: add, compare, partial products ----------------
  logic        v2_q, r3;
  logic [3:0]  op2_q;
  logic [63:0] a2_q, pv2_q, sum2_q, dif2_q, abs2_q, pll2_q, absb2_q;
  logic [31:0] plh2_q, phl2_q;
  logic        cmp2_q, bz2_q, neg2_q;
  logic [63:0] abs_a, abs_b;
  logic        cmp_c;

  assign r2 = !v2_q || r3;

  always_comb begin
    abs_a = a1_q[63] ? (64'd0 - a1_q) : a1_q;
    abs_b = b1_q[63] ? (64'd0 - b1_q) : b1_q;
    case (op1_q)
      bsia_pkg::OP_EQ: cmp_c = (a1_q == b1_q);
      bsia_pkg::OP_LT: cmp_c = ($signed(a1_q) < $signed(b1_q));
      bsia_pkg::OP_GT: cmp_c = ($signed(a1_q) > $signed(b1_q));
      default:         cmp_c = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (r2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r2 && v1_q) begin
      op2_q   <= op1_q;
      a2_q    <= a1_q;
      pv2_q   <= pv1_q;
      sum2_q  <= a1_q + b1_q;
      dif2_q  <= a1_q - b1_q;
      abs2_q  <= abs_a;
      absb2_q <= abs_b;
      pll2_q  <= a1_q[31:0] * b1_q[31:0];
      plh2_q  <= 32'(a1_q[31:0] * b1_q[63:32]);
      phl2_q  <= 32'(a1_q[63:32] * b1_q[31:0]);
      cmp2_q  <= cmp_c;
      bz2_q   <= (b1_q == 64'd0);
      neg2_q  <= a1_q[63] ^ b1_q[63];
    end
  end

  // ---------------- stage 3: select result, load the divider ----------------
  logic          v3_q, rdc;
  logic [DPW-1:0] pay3_q, pay3_d;
  logic [QW-1:0] nq3_q;
  logic [63:0]   dvs3_q;
  logic [63:0]   wide3, src3, mul3;
  logic [1:0]    flt3;
  logic          isdiv3;

  assign r3 = !v3_q || rdc;

  always_comb begin
    mul3   = pll2_q + {plh2_q + phl2_q, 32'd0};
    wide3  = 64'd0;
    src3   = 64'd0;
    flt3   = bsia_pkg::FAULT_NONE;
    isdiv3 = 1'b0;
    case (op2_q)
      bsia_pkg::OP_ENCODE: src3  = pv2_q;
      bsia_pkg::OP_DECODE: wide3 = a2_q;
      bsia_pkg::OP_ABS:    wide3 = abs2_q;
      bsia_pkg::OP_ADD:    wide3 = sum2_q;
      bsia_pkg::OP_SUB:    wide3 = dif2_q;
      bsia_pkg::OP_MUL:    wide3 = mul3;
      bsia_pkg::OP_DIV: begin
        if (bz2_q) begin
          flt3 = bsia_pkg::FAULT_DIV0;
        end else begin
          isdiv3 = 1'b1;
        end
      end
      default: wide3 = 64'd0;
    endcase
    if (op2_q != bsia_pkg::OP_ENCODE) begin
      src3 = wide3;
    end
    pay3_d = {neg2_q, isdiv3, flt3, cmp2_q, src3, wide3};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (r3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r3 && v2_q) begin
      pay3_q <= pay3_d;
      nq3_q  <= abs2_q[QW-1:0];
      dvs3_q <= absb2_q;
    end
  end

  // ---------------- divider chain, one quotient bit per cell ----------------
  logic           dv   [QW+1];
  logic           drdy [QW+1];
  logic [QW-1:0]  drem [QW+1];
  logic [QW-1:0]  dnq  [QW+1];
  logic [63:0]    ddvs [QW+1];
  logic [DPW-1:0] dpay [QW+1];

  assign dv[0]   = v3_q;
  assign rdc     = drdy[0];
  assign drem[0] = '0;
  assign dnq[0]  = nq3_q;
  assign ddvs[0] = dvs3_q;
  assign dpay[0] = pay3_q;

  for (genvar k = 0; k < QW; k++) begin : g_div
    bsia_div_cell #(.QW(QW), .PW(DPW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv[k]),
      .ready_o (drdy[k]),
      .rem_i   (drem[k]),
      .nq_i    (dnq[k]),
      .dvs_i   (ddvs[k]),
      .pay_i   (dpay[k]),
      .valid_o (dv[k+1]),
      .ready_i (drdy[k+1]),
      .rem_o   (drem[k+1]),
      .nq_o    (dnq[k+1]),
      .dvs_o   (ddvs[k+1]),
      .pay_o   (dpay[k+1])
    );
  end

  // ---------------- sign stage: apply quotient sign ----------------
  logic         vs_q, rsg;
  logic [63:0]  sd_q, sw_q, quo;
  logic [2:0]   sf_q;  // cmp, fault
  logic [DPW-1:0] dtail;
  logic [63:0]  qext;

  assign dtail = dpay[QW];
  assign drdy[QW] = !vs_q || rsg;

  always_comb begin
    qext = {{(64 - QW){1'b0}}, dnq[QW]};
    quo  = dtail[132] ? (64'd0 - qext) : qext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q <= 1'b0;
    end else if (drdy[QW]) begin
      vs_q <= dv[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (drdy[QW] && dv[QW]) begin
      sw_q <= dtail[131] ? quo : dtail[63:0];
      sd_q <= dtail[131] ? quo : dtail[127:64];
      sf_q <= dtail[130:128];
    end
  end

  // ---------------- packing chain, three cells ----------------
  logic           ev   [4];
  logic           erdy [4];
  logic [63:0]    ed   [4];
  logic           ec   [4];
  logic [1:0]     ee   [4];
  logic           edn  [4];
  logic [EPW-1:0] epay [4];

  assign ev[0]   = vs_q;
  assign rsg     = erdy[0];
  assign ed[0]   = sd_q;
  assign ec[0]   = 1'b0;
  assign ee[0]   = 2'd0;
  assign edn[0]  = 1'b0;
  assign epay[0] = {sf_q, sw_q};

  for (genvar k = 0; k < 3; k++) begin : g_enc
    bsia_enc_cell #(.MW(MW), .PW(EPW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (ev[k]),
      .ready_o (erdy[k]),
      .d_i     (ed[k]),
      .carry_i (ec[k]),
      .e_i     (ee[k]),
      .done_i  (edn[k]),
      .pay_i   (epay[k]),
      .valid_o (ev[k+1]),
      .ready_i (erdy[k+1]),
      .d_o     (ed[k+1]),
      .carry_o (ec[k+1]),
      .e_o     (ee[k+1]),
      .done_o  (edn[k+1]),
      .pay_o   (epay[k+1])
    );
  end

  // ---------------- output register: round, clamp, flag ----------------
  logic              vo_q;
  logic [63:0]       ow_q;
  logic [MW-1:0]     om_q, om_d;
  logic [1:0]        oe_q, of_q, of_d;
  logic              oc_q;
  logic signed [64:0] mant;
  logic [EPW-1:0]    etail;

  assign etail    = epay[3];
  assign erdy[3]  = !vo_q || m_axis_tready;

  always_comb begin
    mant = $signed({ed[3][63], ed[3]}) + $signed({64'd0, ec[3]});
    of_d = etail[66:65];
    om_d = mant[MW-1:0];
    if (mant > MaxVal) begin
      om_d = MaxVal[MW-1:0];
      of_d = bsia_pkg::FAULT_SAT;
    end else if (mant < -MaxVal) begin
      om_d = MinVal[MW-1:0];
      of_d = bsia_pkg::FAULT_SAT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (erdy[3]) begin
      vo_q <= ev[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (erdy[3] && ev[3]) begin
      ow_q <= etail[63:0];
      oc_q <= etail[64];
      om_q <= om_d;
      oe_q <= ee[3];
      of_q <= of_d;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = {{(OW - MW - 67){1'b0}}, oc_q, oe_q, om_q, ow_q};
  assign m_axis_tuser  = of_q;

endmodule

### src/bsia_div_cell.sv
// One restoring division step: bring down the next dividend bit, subtract
// the divisor where it fits, shift the quotient bit in.
module bsia_div_cell #(
  parameter int unsigned QW = 42,
  parameter int unsigned PW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic [QW-1:0] rem_i,
  input  logic [QW-1:0] nq_i,
  input  logic [63:0]   dvs_i,
  input  logic [PW-1:0] pay_i,
  output logic          valid_o,
  input  logic          ready_i,
  output logic [QW-1:0] rem_o,
  output logic [QW-1:0] nq_o,
  output logic [63:0]   dvs_o,
  output logic [PW-1:0] pay_o
);

  logic          valid_q;
  logic [QW-1:0] rem_q, rem_d, nq_q, nq_d;
  logic [63:0]   dvs_q;
  logic [PW-1:0] pay_q;
  logic [64:0]   trial, diff;
  logic          fits;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    trial = {{(64 - QW){1'b0}}, rem_i, nq_i[QW-1]};
    diff  = trial - {1'b0, dvs_i};
    fits  = trial >= {1'b0, dvs_i};
    rem_d = fits ? diff[QW-1:0] : trial[QW-1:0];
    nq_d  = {nq_i[QW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_q <= rem_d;
      nq_q  <= nq_d;
      dvs_q <= dvs_i;
      pay_q <= pay_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign nq_o    = nq_q;
  assign dvs_o   = dvs_q;
  assign pay_o   = pay_q;

endmodule

### src/bsia_enc_cell.sv
// One step of the packing loop: while the mantissa is out of range, divide
// by 16 (truncating), keep the rounding carry and count the exponent.
module bsia_enc_cell #(
  parameter int unsigned MW = 30,
  parameter int unsigned PW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic [63:0]   d_i,
  input  logic          carry_i,
  input  logic [1:0]    e_i,
  input  logic          done_i,
  input  logic [PW-1:0] pay_i,
  output logic          valid_o,
  input  logic          ready_i,
  output logic [63:0]   d_o,
  output logic          carry_o,
  output logic [1:0]    e_o,
  output logic          done_o,
  output logic [PW-1:0] pay_o
);

  localparam logic signed [64:0] MaxVal = (65'sd1 <<< (MW - 1)) - 65'sd1;

  logic          valid_q;
  logic [63:0]   d_q, d_d, d_bias;
  logic          carry_q, carry_d, done_q, done_d;
  logic [1:0]    e_q, e_d;
  logic [PW-1:0] pay_q;
  logic signed [64:0] sum;
  logic          wide;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    sum     = $signed({d_i[63], d_i}) + $signed({64'd0, carry_i});
    wide    = (sum > MaxVal) || (sum < -MaxVal);
    d_bias  = d_i + (d_i[63] ? 64'd15 : 64'd0);
    d_d     = d_i;
    carry_d = carry_i;
    e_d     = e_i;
    done_d  = done_i;
    if (!done_i) begin
      if (wide) begin
        carry_d = !d_i[63] && d_i[3];
        d_d     = {{4{d_bias[63]}}, d_bias[63:4]};
        e_d     = e_i + 2'd1;
        done_d  = (e_i == 2'd2);
      end else begin
        done_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      d_q     <= d_d;
      carry_q <= carry_d;
      e_q     <= e_d;
      done_q  <= done_d;
      pay_q   <= pay_i;
    end
  end

  assign valid_o = valid_q;
  assign d_o     = d_q;
  assign carry_o = carry_q;
  assign e_o     = e_q;
  assign done_o  = done_q;
  assign pay_o   = pay_q;

endmodule
